FILE: hw/rtl/bpa_pkg.sv
// shared constants, payload types and control structs of the bitmap page allocator
`default_nettype none

package bpa_pkg;

    localparam int MAP_PAGES  = 1024;
    localparam int WORD_W     = 32;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int MAP_ROWS   = MAP_PAGES / WORD_W;
    localparam int ROW_W      = $clog2(MAP_ROWS);
    localparam int IDX_W      = $clog2(MAP_PAGES);
    localparam int COUNT_W    = 11;
    localparam int FRAME_W    = 52;
    localparam int DIV_W      = FRAME_W + 1;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 52;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT = 2'd1;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RESERVE = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [COUNT_W-1:0] page_count;
        logic               aligned_request;
        logic [FRAME_W-1:0] reserve_frame;
    } req_t;

    typedef struct packed {
        logic               success;
        logic [FRAME_W-1:0] grant_frame;
        logic [COUNT_W-1:0] granted_count;
        logic [COUNT_W-1:0] free_after;
    } rsp_t;

    typedef struct packed {
        logic accept;
        logic rsv_sub;
        logic rsv_start;
        logic pass_start;
        logic pass_sel;
        logic div_step;
        logic fetch;
        logic scan_step;
        logic hit;
        logic mark_rd;
        logic mark_wr;
        logic clr_wr;
        logic out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic reinit;
        logic req_alloc;
        logic n_zero;
        logic free_zero;
        logic align;
        logic pass1;
        logic div_done;
        logic rsv_in_range;
        logic scan_end;
        logic scan_hit;
        logic scan_miss;
        logic row_end;
        logic mark_last;
        logic clr_last;
        logic out_free;
    } ctl_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bpa_ctl.sv
// controller state machine of the bitmap page allocator
`default_nettype none

module bpa_ctl
    import bpa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire ctl_sts_t sts,
    output ctl_cmd_t      cmd
);

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DECODE  = 4'd2;
    localparam logic [3:0] S_RSV_CHK = 4'd3;
    localparam logic [3:0] S_DIV     = 4'd4;
    localparam logic [3:0] S_FETCH   = 4'd5;
    localparam logic [3:0] S_SCAN    = 4'd6;
    localparam logic [3:0] S_MARK_RD = 4'd7;
    localparam logic [3:0] S_MARK_WR = 4'd8;
    localparam logic [3:0] S_RESULT  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.rsv_sub = 1'b1;
                priority if (sts.n_zero)
                begin
                    state_next = S_RESULT;
                end
                else if (!sts.req_alloc)
                begin
                    state_next = S_RSV_CHK;
                end
                else if (sts.free_zero)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.pass_start = 1'b1;
                    state_next     = sts.align ? S_DIV : S_FETCH;
                end
            end
            S_RSV_CHK:
            begin
                if (sts.rsv_in_range)
                begin
                    cmd.rsv_start = 1'b1;
                    state_next    = S_FETCH;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                priority if (sts.scan_end)
                begin
                    if (sts.req_alloc && !sts.pass1)
                    begin
                        // wrap around once and search from the pool start
                        cmd.pass_start = 1'b1;
                        cmd.pass_sel   = 1'b1;
                        state_next     = sts.align ? S_DIV : S_FETCH;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
                else if (sts.scan_hit)
                begin
                    cmd.hit    = 1'b1;
                    state_next = S_MARK_RD;
                end
                else if (sts.scan_miss)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = sts.row_end ? S_FETCH : S_SCAN;
                end
            end
            S_MARK_RD:
            begin
                cmd.mark_rd = 1'b1;
                state_next  = S_MARK_WR;
            end
            S_MARK_WR:
            begin
                cmd.mark_wr = 1'b1;
                state_next  = sts.mark_last ? S_RESULT : S_MARK_RD;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
        if (sts.reinit)
        begin
            state_next = S_CLR;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bpa_dp.sv
// datapath of the bitmap page allocator: map memory, scan, divider, marking
`default_nettype none

module bpa_dp
    import bpa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire req_t                  req,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output rsp_t                       rsp,
    input  wire ctl_cmd_t              cmd,
    output ctl_sts_t                   sts
);

    logic [WORD_W-1:0] map_mem [MAP_ROWS];
    logic [WORD_W-1:0] rdata_reg;

    logic [FRAME_W-1:0] base_reg;
    logic [COUNT_W-1:0] psize_reg;
    logic [COUNT_W-1:0] free_reg;
    logic [COUNT_W-1:0] sstart_reg;
    logic [ROW_W-1:0]   clr_row_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic               alloc_reg;
    logic [COUNT_W-1:0] n_reg;
    logic               align_reg;
    logic [FRAME_W-1:0] rframe_reg;
    logic [DIV_W-1:0]   off_reg;
    logic [COUNT_W-1:0] j_reg;
    logic [COUNT_W-1:0] run_reg;
    logic [COUNT_W-1:0] res_reg;
    logic [DIV_W-1:0]   dvd_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic               pass_reg;
    logic [COUNT_W-1:0] lo_reg;
    logic [COUNT_W-1:0] hi_reg;
    logic [ROW_W-1:0]   mark_row_reg;
    logic               ok_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [COUNT_W-1:0] gcount_reg;

    logic [COUNT_W-1:0] cfg_psize;
    logic [COUNT_W-1:0] from;
    logic [COUNT_W-1:0] n_m1;
    logic [COUNT_W-1:0] res_step;
    logic [COUNT_W:0]   div_trial;
    logic               cur_bit;
    logic [COUNT_W-1:0] run_new;
    logic               cand;
    logic [COUNT_W-1:0] s_calc;
    logic [COUNT_W-1:0] hi_m1;
    logic [COUNT_W:0]   rsv_end;
    logic [WORD_W-1:0]  mark_mask;
    logic               mem_wr;
    logic [ROW_W-1:0]   mem_wr_addr;
    logic [WORD_W-1:0]  mem_wr_data;
    logic               mem_rd;
    logic [ROW_W-1:0]   mem_rd_addr;
    logic               reinit;

    assign reinit    = cfg_wr_en && (cfg_index == CFG_POOL_COUNT);
    assign cfg_psize = (cfg_data[COUNT_W-1:0] > COUNT_W'(MAP_PAGES))
                       ? COUNT_W'(MAP_PAGES) : cfg_data[COUNT_W-1:0];

    assign from     = cmd.pass_sel ? '0 : sstart_reg;
    assign n_m1     = n_reg - COUNT_W'(1);
    // residue of base + j modulo n, stepped along with the scan index
    assign res_step = (res_reg == n_m1) ? '0 : res_reg + COUNT_W'(1);
    assign div_trial = {res_reg, dvd_reg[DIV_W-1]};

    assign cur_bit = rdata_reg[j_reg[BIT_W-1:0]];
    assign run_new = cur_bit ? '0 : run_reg + COUNT_W'(1);
    // a run ending at j starts at an aligned frame when base + j + 1 is a multiple of n
    assign cand    = !cur_bit && (run_new >= n_reg)
                     && (!(alloc_reg && align_reg) || (res_reg == n_m1));
    assign s_calc  = j_reg + COUNT_W'(1) - n_reg;
    assign hi_m1   = hi_reg - COUNT_W'(1);
    assign rsv_end = {1'b0, off_reg[COUNT_W-1:0]} + {1'b0, n_reg};

    always_comb
    begin
        for (int b = 0; b < WORD_W; b++)
        begin
            mark_mask[b] =
                ({{(COUNT_W-IDX_W){1'b0}}, mark_row_reg, BIT_W'(b)} >= lo_reg) &&
                ({{(COUNT_W-IDX_W){1'b0}}, mark_row_reg, BIT_W'(b)} < hi_reg);
        end
    end

    assign mem_wr      = cmd.clr_wr || cmd.mark_wr;
    assign mem_wr_addr = cmd.clr_wr ? clr_row_reg : mark_row_reg;
    assign mem_wr_data = cmd.clr_wr ? '0 : (rdata_reg | mark_mask);
    assign mem_rd      = cmd.fetch || cmd.mark_rd;
    assign mem_rd_addr = cmd.fetch ? j_reg[IDX_W-1:BIT_W] : mark_row_reg;

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            map_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd)
        begin
            rdata_reg <= map_mem[mem_rd_addr];
        end
    end

    // control state: configuration, pool bookkeeping, clear sweep, result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            psize_reg     <= COUNT_W'(MAP_PAGES);
            free_reg      <= COUNT_W'(MAP_PAGES);
            sstart_reg    <= '0;
            clr_row_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_row_reg <= clr_row_reg + ROW_W'(1);
            end
            if (cmd.hit)
            begin
                free_reg <= (free_reg >= n_reg) ? free_reg - n_reg : '0;
                if (alloc_reg)
                begin
                    sstart_reg <= s_calc + n_reg;
                end
            end
            if (cfg_wr_en && (cfg_index == CFG_POOL_BASE))
            begin
                base_reg <= cfg_data[FRAME_W-1:0];
            end
            if (reinit)
            begin
                psize_reg   <= cfg_psize;
                free_reg    <= cfg_psize;
                sstart_reg  <= '0;
                clr_row_reg <= '0;
            end
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            alloc_reg  <= (req.req_type == REQ_ALLOC);
            n_reg      <= req.page_count;
            align_reg  <= req.aligned_request;
            rframe_reg <= req.reserve_frame;
            ok_reg     <= (req.page_count == '0);
            frame_reg  <= '0;
            gcount_reg <= '0;
        end
        if (cmd.rsv_sub)
        begin
            off_reg <= {1'b0, rframe_reg} - {1'b0, base_reg};
        end
        if (cmd.pass_start)
        begin
            pass_reg    <= cmd.pass_sel;
            j_reg       <= from;
            run_reg     <= '0;
            res_reg     <= '0;
            dvd_reg     <= {1'b0, base_reg} + DIV_W'(from);
            div_cnt_reg <= DIV_CNT_W'(DIV_W);
        end
        if (cmd.rsv_start)
        begin
            pass_reg <= 1'b1;
            j_reg    <= off_reg[COUNT_W-1:0];
            run_reg  <= '0;
            res_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            res_reg     <= (div_trial >= {1'b0, n_reg})
                           ? COUNT_W'(div_trial - {1'b0, n_reg})
                           : div_trial[COUNT_W-1:0];
            dvd_reg     <= {dvd_reg[DIV_W-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
        end
        if (cmd.scan_step)
        begin
            j_reg   <= j_reg + COUNT_W'(1);
            run_reg <= run_new;
            res_reg <= res_step;
        end
        if (cmd.hit)
        begin
            lo_reg       <= s_calc;
            hi_reg       <= s_calc + n_reg;
            mark_row_reg <= s_calc[IDX_W-1:BIT_W];
            ok_reg       <= 1'b1;
            frame_reg    <= alloc_reg ? base_reg + FRAME_W'(s_calc) : rframe_reg;
            gcount_reg   <= n_reg;
        end
        if (cmd.mark_wr)
        begin
            mark_row_reg <= mark_row_reg + ROW_W'(1);
        end
        if (cmd.out_load)
        begin
            rsp_reg.success       <= ok_reg;
            rsp_reg.grant_frame   <= frame_reg;
            rsp_reg.granted_count <= gcount_reg;
            rsp_reg.free_after    <= free_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        sts.reinit       = reinit;
        sts.req_alloc    = alloc_reg;
        sts.n_zero       = (n_reg == '0);
        sts.free_zero    = (free_reg == '0);
        sts.align        = align_reg;
        sts.pass1        = pass_reg;
        sts.div_done     = (div_cnt_reg == '0);
        sts.rsv_in_range = !off_reg[DIV_W-1]
                           && (off_reg[DIV_W-2:COUNT_W] == '0)
                           && (rsv_end <= {1'b0, psize_reg});
        sts.scan_end     = (j_reg >= psize_reg);
        sts.scan_hit     = cand;
        sts.scan_miss    = !alloc_reg && cur_bit;
        sts.row_end      = &j_reg[BIT_W-1:0];
        sts.mark_last    = (mark_row_reg == hi_m1[IDX_W-1:BIT_W]);
        sts.clr_last     = (clr_row_reg == ROW_W'(MAP_ROWS - 1));
        sts.out_free     = !rsp_valid_reg || !rsp_stall;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bitmap_page_allocator_core.sv
// top level of the bitmap page allocator: controller plus datapath
//
//   channel   direction  handshake             payload
//   cfg       in         cfg_wr_en             cfg_index, cfg_data
//   req       in         req_valid/req_stall   req (req_t)
//   rsp       out        rsp_valid/rsp_stall   rsp (rsp_t)
//
// the map lives in a 32 x 32-bit memory; the scan tests one page per cycle
// and refetches the map word each time it enters a new 32-page row
// an aligned allocate runs a bit-serial modulo of the pool base plus start by n
// before each search pass; marking a run reads and rewrites each row touched
// reset and a pool_page_count write start a clear sweep of all 32 map rows with req stalled
// a finished word waits in the rsp register while rsp_stall is high
`default_nettype none

module bitmap_page_allocator_core
    import bpa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire req_t                  req,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output rsp_t                       rsp
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    bpa_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    bpa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// self-checking testbench of the bitmap page allocator core
`timescale 1ns / 100ps
`default_nettype none

module tb;
    import bpa_pkg::*;

    localparam int  NUM_RANDOM = 2000;
    localparam longint LIMIT   = 12000000;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    bitmap_page_allocator_core DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    // allocator shadow state
    logic [FRAME_W-1:0] base_frame;
    logic [COUNT_W-1:0] pool_pages;
    bit                 page_used [MAP_PAGES];
    int unsigned        pages_free;
    int unsigned        next_start;

    req_t   pending_reqs [$];
    rsp_t   expected_rsps [$];
    int     mismatches;
    longint cycle_count;
    bit     hold_rsp;
    int     hold_cycles;
    bit     req_taken;

    function automatic int unsigned pool_span();
        return (pool_pages > MAP_PAGES) ? MAP_PAGES : int'(pool_pages);
    endfunction

    function automatic void clear_pool();
        foreach (page_used[i]) page_used[i] = 0;
        pages_free = pool_span();
        next_start = 0;
    endfunction

    function automatic bit search_run(int unsigned from, int unsigned n, bit align,
                                      output int unsigned found);
        int unsigned run;
        int unsigned s;
        logic [FRAME_W:0] fr;
        run = 0;
        found = 0;
        for (int unsigned j = from; j < pool_span(); j++)
        begin
            if (page_used[j])
            begin
                run = 0;
                continue;
            end
            run++;
            if (run >= n)
            begin
                s = j + 1 - n;
                fr = {1'b0, base_frame} + s;
                if (!align || (fr % n) == 0)
                begin
                    found = s;
                    return 1;
                end
            end
        end
        return 0;
    endfunction

    function automatic void claim_run(int unsigned s, int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            if (s + k < MAP_PAGES) page_used[s + k] = 1;
        pages_free = (pages_free >= n) ? pages_free - n : 0;
    endfunction

    function automatic rsp_t allocate_result(req_t r);
        rsp_t o;
        int unsigned n;
        int unsigned s;
        int unsigned off;
        bit hit;
        bit clear;
        logic [FRAME_W+1:0] lo;
        logic [FRAME_W+1:0] hi;
        o = '0;
        n = r.page_count;
        if (n == 0)
        begin
            o.success = 1;
        end
        else if (r.req_type == REQ_ALLOC)
        begin
            hit = 0;
            if (pages_free != 0)
            begin
                hit = search_run(next_start, n, r.aligned_request, s);
                if (!hit) hit = search_run(0, n, r.aligned_request, s);
            end
            if (hit)
            begin
                claim_run(s, n);
                next_start = s + n;
                o.success = 1;
                o.grant_frame = base_frame + FRAME_W'(s);
                o.granted_count = COUNT_W'(n);
            end
        end
        else
        begin
            lo = {2'b0, r.reserve_frame} + n;
            hi = {2'b0, base_frame} + pool_span();
            if (r.reserve_frame >= base_frame && lo <= hi)
            begin
                off = int'(r.reserve_frame - base_frame);
                clear = 1;
                for (int unsigned k = 0; k < n; k++)
                    if (page_used[off + k]) clear = 0;
                if (clear)
                begin
                    claim_run(off, n);
                    o.success = 1;
                    o.grant_frame = r.reserve_frame;
                    o.granted_count = COUNT_W'(n);
                end
            end
        end
        o.free_after = COUNT_W'(pages_free);
        return o;
    endfunction

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // remember whether the offered word went in at this rising edge
    always @(posedge clk)
    begin
        req_taken <= rst_n && req_valid && !req_stall;
    end

    // sender: bursts and gaps
    int burst_left;
    int gap_left;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 0;
        end
        else if (req_valid && req_taken)
        begin
            // word was taken at the last rising edge
            void'(pending_reqs.pop_front());
            if (pending_reqs.size() != 0 && burst_left > 0 && gap_left == 0)
            begin
                req <= pending_reqs[0];
                burst_left <= burst_left - 1;
            end
            else
            begin
                req_valid <= 0;
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                burst_left <= $urandom_range(1, 12);
            end
        end
        else if (!req_valid)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
            end
            else if (pending_reqs.size() != 0)
            begin
                req <= pending_reqs[0];
                req_valid <= 1;
            end
        end
    end

    // receiver: own stall pattern plus long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 0;
        end
        else if (hold_rsp)
        begin
            rsp_stall <= 1;
            if (hold_cycles >= 3000)
            begin
                hold_rsp <= 0;
                hold_cycles <= 0;
            end
            else
            begin
                hold_cycles <= hold_cycles + 1;
            end
        end
        else
        begin
            rsp_stall <= (cycle_count[9:8] == 2'b01) ? ($urandom_range(0, 1) == 0)
                                                      : ($urandom_range(0, 7) == 0);
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && req_valid && !req_stall)
            expected_rsps.push_back(allocate_result(req));
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %p", rsp);
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.success !== want.success || rsp.grant_frame !== want.grant_frame
                    || rsp.granted_count !== want.granted_count
                    || rsp.free_after !== want.free_after)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word mismatch: want %p got %p", want, rsp);
                end
            end
        end
    end

    task automatic drain();
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (2500) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 0;
        if (idx == CFG_POOL_BASE)
        begin
            base_frame = val;
        end
        else if (idx == CFG_POOL_COUNT)
        begin
            pool_pages = val[COUNT_W-1:0];
            clear_pool();
        end
    endtask

    function automatic req_t make_req(bit rtype, int unsigned n, bit al,
                                      logic [FRAME_W-1:0] fr);
        req_t r;
        r.req_type = rtype;
        r.page_count = COUNT_W'(n);
        r.aligned_request = al;
        r.reserve_frame = fr;
        return r;
    endfunction

    function automatic req_t random_req();
        int unsigned n;
        int sel;
        logic [FRAME_W-1:0] fr;
        sel = $urandom_range(0, 99);
        if (sel < 70) n = $urandom_range(1, 8);
        else if (sel < 85) n = $urandom_range(9, 64);
        else if (sel < 88) n = $urandom_range(65, 2047);
        else if (sel < 92) n = 0;
        else n = $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0)
            fr = FRAME_W'({$urandom, $urandom});
        else
            fr = base_frame + FRAME_W'($urandom_range(0, pool_span() + 4));
        return make_req($urandom_range(0, 2) == 0, n, 1'($urandom_range(0, 1)), fr);
    endfunction

    task automatic random_phase(int cnt);
        for (int i = 0; i < cnt; i++)
        begin
            pending_reqs.push_back(random_req());
            if (pending_reqs.size() > 40)
                while (pending_reqs.size() > 10) @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_index = CFG_POOL_BASE;
        cfg_data = '0;
        req = '0;
        cycle_count = 0;
        mismatches = 0;
        hold_rsp = 0;
        hold_cycles = 0;
        burst_left = 4;
        gap_left = 0;
        base_frame = '0;
        pool_pages = 1024;
        clear_pool();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: zero requests, full pool, alignment, reserve edges
        write_reg(CFG_POOL_BASE, 52'd3);
        pending_reqs.push_back(make_req(REQ_ALLOC, 0, 0, '0));
        pending_reqs.push_back(make_req(REQ_RESERVE, 0, 1, '1));
        pending_reqs.push_back(make_req(REQ_ALLOC, 5, 1, '0));
        pending_reqs.push_back(make_req(REQ_ALLOC, 1, 0, '0));
        pending_reqs.push_back(make_req(REQ_ALLOC, 8, 1, '0));
        pending_reqs.push_back(make_req(REQ_RESERVE, 4, 0, 52'd3));
        pending_reqs.push_back(make_req(REQ_RESERVE, 2, 0, 52'd2));
        pending_reqs.push_back(make_req(REQ_RESERVE, 2, 0, 52'd1026));
        pending_reqs.push_back(make_req(REQ_RESERVE, 1, 0, 52'd1026));
        pending_reqs.push_back(make_req(REQ_RESERVE, 1, 0, '1));
        pending_reqs.push_back(make_req(REQ_ALLOC, 2047, 0, '0));
        pending_reqs.push_back(make_req(REQ_ALLOC, 1000, 0, '0));
        pending_reqs.push_back(make_req(REQ_ALLOC, 64, 0, '0));
        pending_reqs.push_back(make_req(REQ_ALLOC, 3, 0, '0));
        drain();

        // frame wrap with a top-of-range base, and the empty pool
        write_reg(CFG_POOL_BASE, '1);
        write_reg(CFG_POOL_COUNT, 52'd16);
        pending_reqs.push_back(make_req(REQ_ALLOC, 16, 0, '0));
        pending_reqs.push_back(make_req(REQ_ALLOC, 1, 0, '0));
        pending_reqs.push_back(make_req(REQ_ALLOC, 1, 1, '0));
        drain();
        write_reg(CFG_POOL_COUNT, 52'd0);
        pending_reqs.push_back(make_req(REQ_ALLOC, 1, 0, '0));
        pending_reqs.push_back(make_req(REQ_RESERVE, 1, 0, '1));
        drain();
        write_reg(CFG_POOL_COUNT, 52'd2047);
        pending_reqs.push_back(make_req(REQ_ALLOC, 1024, 0, '0));
        pending_reqs.push_back(make_req(REQ_ALLOC, 1, 0, '0));
        drain();

        // random phases over several pool settings
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(CFG_POOL_BASE, (ph % 3 == 0) ? 52'({$urandom, $urandom})
                                                   : 52'($urandom_range(0, 4096)));
            write_reg(CFG_POOL_COUNT, (ph == 7) ? 52'd1024 : 52'($urandom_range(8, 300)));
            if (ph == 2) hold_rsp = 1;
            random_phase(NUM_RANDOM / 8);
            drain();
        end

        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
